[hdl/lsh_pkg.sv]
// Shared types, constants and helper functions of the Laplacian sharpening core.
package lsh_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_ADDR_W = 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int FIFO_DEPTH = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = CFG_ADDR_W'(1);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // One line store entry: the pixel of row r-2 and the pixel of row r-1.
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } t_entry;

    // Frame geometry as last column and last row indexes.
    typedef struct packed {
        logic [COL_W-1:0] last_col;
        logic [ROW_W-1:0] last_row;
    } t_dims;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_result;

    // Results produced by one accepted pixel; slot 1 is only used together with slot 0.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    // Clamps a size register to 3..hi and returns the index of the last element.
    function automatic int unsigned dim_last(logic [CFG_W-1:0] v, int unsigned hi);
        int unsigned val;
        val = int'(v);
        if (val < 3) begin
            return 2;
        end
        if (val > hi) begin
            return hi - 1;
        end
        return val - 1;
    endfunction

endpackage

[hdl/lsh_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module lsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/lsh_window.sv]
// Raster counters, line store access and the sharpening arithmetic.
module lsh_window import lsh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_pixel,
    input  t_dims            i_dims,
    output t_push            o_push
);

    localparam int SUM_W = PIX_W + 4;

    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    t_entry           r_cur;
    logic [PIX_W-1:0] r_left;
    t_entry           w_next;
    t_entry           w_wdata;
    logic [COL_W-1:0] w_raddr;
    logic             w_interior;
    logic [SUM_W-1:0] w_sum;
    logic [PIX_W-1:0] w_sat;

    // Entry c+1 sits on the RAM output while the pixel of column c is waiting.
    lsh_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_accept),
        .i_waddr (r_col),
        .i_wdata (w_wdata),
        .i_re    (i_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_next)
    );

    assign w_wdata = '{older: r_cur.newer, newer: i_pixel};

    // Prefetch two columns ahead; near the row end fetch the first two entries of the row.
    always_comb begin
        if (r_col == i_dims.last_col - COL_W'(1)) begin
            w_raddr = COL_W'(0);
        end else if (r_col == i_dims.last_col) begin
            w_raddr = COL_W'(1);
        end else begin
            w_raddr = r_col + COL_W'(2);
        end
    end

    always_comb begin
        if (r_col != i_dims.last_col) begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end else begin
            n_col = COL_W'(0);
            n_row = (r_row != i_dims.last_row) ? r_row + ROW_W'(1) : ROW_W'(0);
        end
    end

    // Five times the centre less the four neighbors, in modular arithmetic wide enough
    // that the top bit is the sign.
    always_comb begin
        w_sum = (SUM_W'(r_cur.newer) << 2) + SUM_W'(r_cur.newer)
              - SUM_W'(r_cur.older) - SUM_W'(i_pixel)
              - SUM_W'(r_left) - SUM_W'(w_next.newer);
        if (w_sum[SUM_W-1]) begin
            w_sat = '0;
        end else if (w_sum > SUM_W'(255)) begin
            w_sat = '1;
        end else begin
            w_sat = w_sum[PIX_W-1:0];
        end
    end

    assign w_interior = (r_row >= ROW_W'(2)) && (r_col != COL_W'(0))
                      && (r_col != i_dims.last_col);

    always_comb begin
        o_push.v0       = i_accept && (r_row != ROW_W'(0));
        o_push.r0.pixel = w_interior ? w_sat : '0;
        o_push.r0.last  = 1'b0;
        o_push.v1       = i_accept && (r_row == i_dims.last_row);
        o_push.r1.pixel = '0;
        o_push.r1.last  = (r_col == i_dims.last_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cur  <= w_next;
            r_left <= r_cur.newer;
        end
    end

endmodule

[hdl/lsh_out_fifo.sv]
// Small result queue that takes up to two results per cycle and delivers one.
module lsh_out_fifo import lsh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_pixel,
    output logic             o_last
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_pop;

    assign o_valid = (r_count != CNT_W'(0));
    assign w_pop   = o_valid && i_ready;
    // Room for the worst case of two results from the next pixel.
    assign o_room  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_pixel = r_mem[r_rptr].pixel;
    assign o_last  = r_mem[r_rptr].last;

    assign n_count = r_count + CNT_W'(i_push.v0) + CNT_W'(i_push.v1) - CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(i_push.v0) + PTR_W'(i_push.v1);
            r_rptr  <= r_rptr + PTR_W'(w_pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[r_wptr + PTR_W'(i_push.v0)] <= i_push.r1;
        end
    end

endmodule

[hdl/laplacian_sharpen_3x3_core.sv]
// Top level of the 3x3 Laplacian sharpening core: configuration, line store and output queue.
//
// The core takes 8-bit grayscale pixels in raster order, one transfer per clock, and
// returns 5*centre minus the four direct neighbors, saturated to 0..255, with the first and
// last row and column forced to zero. A pixel of row r produces the result of row r-1 at the
// same column, so row 0 produces nothing and each pixel of the last row produces two
// results: the row above and the zero of the last row itself. A frame gives exactly
// width*height results in raster order, the last two rows interleaved by column; tlast marks
// the final one. The input side sustains one pixel per clock unless the output stalls; during
// the last row the single output transfer per clock throttles tready. A result is pushed into
// the output queue at the edge that accepts its pixel and can be taken on the following
// clock. Both previous rows live in one synchronous RAM of MAX_WIDTH entries, each holding the
// pixels of rows r-2 and r-1 of a column; the entry two columns ahead is prefetched so that
// each pixel needs one read and one write. There is no clearing pass after reset: the first
// two rows of each frame fill the store before it is used. Writing either size register
// restarts the frame at row 0, column 0; sizes are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
module laplacian_sharpen_3x3_core import lsh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // Pixel input stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [PIX_W-1:0]      i_s_axis_tdata,  // [7:0] pixel_in
    // Result output stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [PIX_W-1:0]      o_m_axis_tdata,  // [7:0] pixel_out
    output logic                  o_m_axis_tlast   // frame_last
);

    t_dims r_dims;
    logic  w_restart;
    logic  w_accept;
    t_push w_push;

    // Size registers are kept as clamped last-index values so the datapath never sees an
    // out-of-range size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.last_col <= COL_W'(dim_last(WIDTH_RESET, MAX_WIDTH));
            r_dims.last_row <= ROW_W'(dim_last(HEIGHT_RESET, MAX_HEIGHT));
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WIDTH: begin
                    r_dims.last_col <= COL_W'(dim_last(i_cfg_data, MAX_WIDTH));
                end
                REG_HEIGHT: begin
                    r_dims.last_row <= ROW_W'(dim_last(i_cfg_data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    // Any write to a known register sends the raster position back to the frame start.
    assign w_restart = i_cfg_we && ((i_cfg_addr == REG_WIDTH) || (i_cfg_addr == REG_HEIGHT));
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;

    lsh_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_accept  (w_accept),
        .i_pixel   (i_s_axis_tdata),
        .i_dims    (r_dims),
        .o_push    (w_push)
    );

    // The queue decouples the two sides: ready depends only on its own fill level.
    lsh_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_pixel (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule
